// ----- design/bdg_pkg.sv -----
// bdg_pkg: shared types and constants for the button debounce / gesture core.
// Used by bdg_cfg, bdg_gesture and button_debounce_gesture_detector_core.
package bdg_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [IDX_W-1:0] REG_DOUBLE_PRESS = 2'd1;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
	localparam logic [CFG_W-1:0] DOUBLE_PRESS_RST = 16'd400;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;

	// press count codes
	localparam logic [1:0] CNT_NONE   = 2'd0;
	localparam logic [1:0] CNT_SINGLE = 2'd1;
	localparam logic [1:0] CNT_DOUBLE = 2'd2;
	localparam logic [1:0] CNT_BAD    = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] double_press_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic              raw_pressed;
		logic [TIME_W-1:0] time_ms;
		logic              consume;
		logic              clear_gestures;
	} sample_t;

	typedef struct packed {
		logic pressed;
		logic click;
		logic long_press;
		logic double_click;
	} result_t;

endpackage

// ----- design/button_debounce_gesture_detector_core.sv -----
// button_debounce_gesture_detector_core: top level, input register, result register.
// Depends on bdg_pkg, bdg_cfg, bdg_gesture.
//
//   channel  handshake                  payload
//   in       in_valid / in_stall        raw_pressed, time_ms, consume, clear_gestures
//   out      out_valid / out_stall      pressed, click, long_press, double_click
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low; a sample passes the input register, then the result register.
// The gesture update is one pass of subtract/compare logic between the two registers.
// Reset clears all gesture state and loads the default timing registers.
// A stalled result holds; one more sample is taken into the input register meanwhile.
// cfg_ready is always high.
module button_debounce_gesture_detector_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      raw_pressed,
	input  logic [bdg_pkg::TIME_W-1:0] time_ms,
	input  logic                      consume,
	input  logic                      clear_gestures,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      pressed,
	output logic                      click,
	output logic                      long_press,
	output logic                      double_click,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bdg_pkg::IDX_W-1:0] cfg_index,
	input  logic [bdg_pkg::CFG_W-1:0] cfg_data
);

	bdg_pkg::cfg_t    cfg;
	bdg_pkg::sample_t smp_s1;
	logic             valid_s1;
	bdg_pkg::result_t res;
	bdg_pkg::result_t res_q;
	logic             out_valid_q;
	logic             adv;
	logic             in_xfer;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	bdg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			smp_s1.raw_pressed    <= raw_pressed;
			smp_s1.time_ms        <= time_ms;
			smp_s1.consume        <= consume;
			smp_s1.clear_gestures <= clear_gestures;
		end
	end

	bdg_gesture u_gesture (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign pressed      = res_q.pressed;
	assign click        = res_q.click;
	assign long_press   = res_q.long_press;
	assign double_click = res_q.double_click;

`ifndef SYNTHESIS
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room to advance");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced sample produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule

// ----- design/bdg_cfg.sv -----
// bdg_cfg: timing configuration registers written over the cfg channel.
// Depends on bdg_pkg (cfg_t, register indexes, reset values).
module bdg_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bdg_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bdg_pkg::CFG_W-1:0]  cfg_data,
	output bdg_pkg::cfg_t              cfg
);

	bdg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bdg_pkg::DEBOUNCE_RST;
			cfg_q.double_press_ms <= bdg_pkg::DOUBLE_PRESS_RST;
			cfg_q.long_press_ms   <= bdg_pkg::LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bdg_pkg::REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data;
				bdg_pkg::REG_DOUBLE_PRESS: cfg_q.double_press_ms <= cfg_data;
				bdg_pkg::REG_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/bdg_gesture.sv -----
// bdg_gesture: debounce and gesture state with its combinational update logic.
// Depends on bdg_pkg (cfg_t, sample_t, result_t, press count codes).
module bdg_gesture (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bdg_pkg::sample_t smp,
	input  bdg_pkg::cfg_t    cfg,
	output bdg_pkg::result_t res
);

	logic                       prev_raw_q;
	logic [bdg_pkg::TIME_W-1:0] raw_change_time_q;
	logic                       stable_q;
	logic [bdg_pkg::TIME_W-1:0] press_start_time_q;
	logic                       long_flag_q;
	logic [1:0]                 press_count_q;
	logic [bdg_pkg::TIME_W-1:0] prev_press_time_q;

	logic                       raw_chg;
	logic [bdg_pkg::TIME_W-1:0] since_raw;
	logic [bdg_pkg::TIME_W-1:0] since_start;
	logic [bdg_pkg::TIME_W-1:0] since_prev;
	logic                       settled;
	logic                       held_long;
	logic                       quick;
	logic                       stable_d;
	logic                       long_d;
	logic [1:0]                 cnt_d;
	logic                       start_press;
	logic                       ev_click;
	logic                       ev_long;
	logic                       ev_double;
	logic                       long_n;
	logic [1:0]                 cnt_n;

	always_comb begin
		raw_chg     = smp.raw_pressed != prev_raw_q;
		since_raw   = smp.time_ms - raw_change_time_q;
		since_start = smp.time_ms - press_start_time_q;
		since_prev  = smp.time_ms - prev_press_time_q;
		// a fresh raw edge restarts the window, so it never settles this sample
		settled     = !raw_chg && (since_raw > {16'd0, cfg.debounce_ms});
		held_long   = since_start >= {16'd0, cfg.long_press_ms};
		quick       = since_prev < {16'd0, cfg.double_press_ms};

		long_d      = smp.clear_gestures ? 1'b0 : long_flag_q;
		cnt_d       = smp.clear_gestures ? bdg_pkg::CNT_NONE : press_count_q;
		stable_d    = stable_q;
		start_press = 1'b0;

		if (settled) begin
			if (smp.raw_pressed != stable_q) begin
				stable_d = smp.raw_pressed;
				if (smp.raw_pressed) begin
					start_press = 1'b1;
					long_d      = 1'b0;
					cnt_d       = quick ? bdg_pkg::CNT_DOUBLE : bdg_pkg::CNT_SINGLE;
				end else if (held_long) begin
					long_d = 1'b1;
				end
			end else if (stable_q && !long_d && held_long) begin
				long_d = 1'b1;
			end
		end

		ev_click  = (cnt_d == bdg_pkg::CNT_SINGLE) && !stable_d && !long_d;
		ev_long   = long_d && stable_d;
		ev_double = (cnt_d == bdg_pkg::CNT_DOUBLE) && !stable_d;

		cnt_n  = (smp.consume && (ev_click || ev_double)) ? bdg_pkg::CNT_NONE : cnt_d;
		long_n = (smp.consume && ev_long) ? 1'b0 : long_d;

		res.pressed      = stable_d;
		res.click        = ev_click;
		res.long_press   = ev_long;
		res.double_click = ev_double;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q         <= 1'b0;
			raw_change_time_q  <= '0;
			stable_q           <= 1'b0;
			press_start_time_q <= '0;
			long_flag_q        <= 1'b0;
			press_count_q      <= bdg_pkg::CNT_NONE;
			prev_press_time_q  <= '0;
		end else if (en) begin
			prev_raw_q    <= smp.raw_pressed;
			stable_q      <= stable_d;
			long_flag_q   <= long_n;
			press_count_q <= cnt_n;
			if (raw_chg) begin
				raw_change_time_q <= smp.time_ms;
			end
			if (start_press) begin
				press_start_time_q <= smp.time_ms;
				prev_press_time_q  <= smp.time_ms;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		press_count_q != bdg_pkg::CNT_BAD)
		else $error("press count reached an illegal code");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stable_q) && $stable(press_count_q) && $stable(long_flag_q))
		else $error("gesture state moved without a sample");

	a_consume_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		en && smp.consume && (ev_click || ev_double) |=> press_count_q == bdg_pkg::CNT_NONE)
		else $error("consumed click left a press count");

	a_consume_long: assert property (@(posedge clk) disable iff (!arst_n)
		en && smp.consume && ev_long |=> !long_flag_q)
		else $error("consumed long press left the long flag");
`endif

endmodule
